[rtl/logistic_loss_gradient_macros.svh]
// assertion macros shared by the logistic loss and gradient rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef LOGISTIC_LOSS_GRADIENT_MACROS_SVH
`define LOGISTIC_LOSS_GRADIENT_MACROS_SVH
`ifndef SYNTHESIS
`define LLG_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("llg assertion failed");
`define LLG_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("llg assertion failed");
`else
`define LLG_ASSERT_IMP(name, clk, rstn, ante, cons)
`define LLG_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

[rtl/llg_pkg.sv]
// types, constants and table builder for the logistic loss and gradient block
// no dependencies; used by llg_rom and logistic_loss_gradient
package llg_pkg;

    localparam int TAB_N = 962;
    localparam int LIM_EXP = 61440;
    localparam int LIM_SOFT = 32768;
    localparam int P_ONE = 65536;
    localparam logic [63:0] STEP_EXP = 64'd4228380000;
    localparam logic REG_FEATURE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_FEATURE = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT_MUL, S_DOT_ACC, S_ROM0, S_ROM1, S_ROM2,
        S_SIG_MUL, S_SP_MUL, S_LOSS, S_GRD_MUL, S_GRD_ACC, S_READ
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [5:0]         index;
        logic signed [15:0] value;
        logic               label;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_index;
        logic signed [47:0] out_value;
        logic               is_loss;
        logic               last_result;
    } t_out_item;

    // rom word: sigmoid in [33:17], softplus remainder in [16:0], both q.16
    typedef logic [33:0] t_rom [0:TAB_N-1];

    // restoring division for the table builder, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_rom build_rom();
        t_rom        tab;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sg;
        logic [63:0] sp;
        e = 64'd1 << 32;
        for (int k = 0; k < TAB_N - 1; k++) begin
            den = (64'd1 << 32) + e;
            z = udiv64(e << 30, (64'd1 << 33) + e);
            z2 = (z * z) >> 30;
            term = z;
            sum = 64'd0;
            sg = udiv64((64'd1 << 48) + (den >> 1), den);
            for (int j = 0; j < 12; j++) begin
                sum = sum + udiv64(term, 64'(2 * j + 1));
                term = (term * z2) >> 30;
            end
            sp = ((sum << 1) + (64'd1 << 13)) >> 14;
            tab[k] = {sg[16:0], sp[16:0]};
            e = (e * STEP_EXP + (64'd1 << 31)) >> 32;
        end
        tab[TAB_N-1] = tab[TAB_N-2];
        return tab;
    endfunction

    // 48-bit saturating add
    function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                   input logic signed [47:0] t);
        logic signed [48:0] r;
        r = 49'(acc) + 49'(t);
        if (r[48] != r[47]) begin
            return r[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r[47:0];
    endfunction

endpackage

[rtl/logistic_loss_gradient.sv]
// logistic regression loss and gradient accumulator, top level
// depends on llg_pkg, llg_rom and logistic_loss_gradient_macros.svh
//
// Usage: write feature_count over the apb port (address 0) while idle.
// Input items (valid/ready): mode 0 loads coefficient[index], mode 1 clears
// gradients, loss, feature position and dot product, mode 2 feeds the next
// feature of the current sample (label sampled on the last one), mode 3
// reads out n gradients then the loss on the output channel.
// Timing: load and clear complete in the idle state; a feature passes through
// the dot product states on the single shared 18x18 multiplier; the feature
// that closes a sample then runs the table lookups and loss update and one
// multiply-accumulate per gradient. A readout sends n + 1 transfers, one per cycle while the
// receiver is ready; a stalled receiver holds the output register and the
// sequencer waits, the input side stays busy during the readout.
// Reset (synchronous, active low) zeroes coefficients, accumulators and
// feature position and sets feature_count to 1.
`include "logistic_loss_gradient_macros.svh"
module logistic_loss_gradient
    import llg_pkg::*;
#(
    parameter int MAX_FEATURES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam logic [5:0] MAX6 = 6'(MAX_FEATURES);

    t_state r_state, n_state;
    logic [5:0] r_fc;
    t_in_item r_item;
    logic [5:0] r_pos;
    logic signed [39:0] r_dot;
    logic signed [15:0] r_coef [MAX_FEATURES];
    logic signed [15:0] r_buf [MAX_FEATURES];
    logic signed [47:0] r_grad [MAX_FEATURES];
    logic signed [47:0] r_loss;
    logic signed [27:0] r_v;
    logic [5:0] r_f;
    logic r_a_big;
    logic [9:0] r_k;
    logic [33:0] r_t0, r_t1;
    logic signed [17:0] r_s;
    logic signed [35:0] r_prod;
    logic signed [17:0] r_w;
    logic r_lab;
    logic [5:0] r_cnt;
    t_out_item r_out;
    logic r_ov;

    logic in_acc, out_free;
    logic [5:0] n_act, pos_c;
    logic [6:0] pos_inc, cnt_inc;
    logic signed [17:0] mul_a, mul_b;
    logic [9:0] rom_addr;
    logic [33:0] rom_q;
    logic signed [27:0] v_c;
    logic [27:0] a_mag;
    logic [15:0] a_clamp;
    logic signed [17:0] dsig, dsp, s_i, l_i, p_c, lz, w_c;
    logic signed [28:0] sp_c;
    logic signed [29:0] term_c;

    llg_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FEATURE_COUNT) ? {26'd0, r_fc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= 6'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_FEATURE_COUNT) begin
            r_fc <= pwdata[5:0];
        end
    end

    // active feature count and position helpers
    assign n_act = (r_fc == 6'd0) ? 6'd1 : ((r_fc > MAX6) ? MAX6 : r_fc);
    assign pos_c = (r_pos >= MAX6) ? MAX6 - 6'd1 : r_pos;
    assign pos_inc = {1'b0, pos_c} + 7'd1;
    assign cnt_inc = {1'b0, r_cnt} + 7'd1;
    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;

    // lookup argument from the finished dot product
    assign v_c = r_dot[39:12];
    assign a_mag = v_c[27] ? 28'(-v_c) : 28'(v_c);
    assign a_clamp = (a_mag > 28'(LIM_EXP)) ? 16'(LIM_EXP) : a_mag[15:0];

    // interpolation terms
    assign dsig = signed'({1'b0, r_t1[33:17]}) - signed'({1'b0, r_t0[33:17]});
    assign dsp = signed'({1'b0, r_t1[16:0]}) - signed'({1'b0, r_t0[16:0]});
    assign s_i = signed'({1'b0, r_t0[33:17]}) + 18'((r_prod + 36'sd32) >>> 6);
    assign l_i = signed'({1'b0, r_t0[16:0]}) + 18'((r_prod + 36'sd32) >>> 6);

    // probability, softplus and loss term
    always_comb begin
        if (r_v > 28'sd61440) begin
            p_c = 18'sd65536;
        end else if (r_v < -28'sd61440) begin
            p_c = 18'sd0;
        end else if (!r_v[27]) begin
            p_c = r_s;
        end else begin
            p_c = 18'sd65536 - r_s;
        end
        lz = r_a_big ? 18'sd0 : l_i;
        if (r_v > 28'(LIM_SOFT)) begin
            sp_c = 29'(r_v);
        end else begin
            sp_c = ((r_v > 28'sd0) ? 29'(r_v) : 29'sd0) + 29'((lz + 18'sd8) >>> 4);
        end
        term_c = 30'(sp_c) - (r_lab ? 30'(r_v) : 30'sd0);
        w_c = p_c - (r_lab ? 18'sd65536 : 18'sd0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode)
                        MODE_FEATURE: n_state = S_DOT_MUL;
                        MODE_READ:    n_state = S_READ;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_DOT_MUL: n_state = S_DOT_ACC;
            S_DOT_ACC: n_state = (pos_inc >= {1'b0, n_act}) ? S_ROM0 : S_IDLE;
            S_ROM0:    n_state = S_ROM1;
            S_ROM1:    n_state = S_ROM2;
            S_ROM2:    n_state = S_SIG_MUL;
            S_SIG_MUL: n_state = S_SP_MUL;
            S_SP_MUL:  n_state = S_LOSS;
            S_LOSS:    n_state = S_GRD_MUL;
            S_GRD_MUL: n_state = S_GRD_ACC;
            S_GRD_ACC: n_state = (cnt_inc >= {1'b0, n_act}) ? S_IDLE : S_GRD_MUL;
            S_READ: begin
                if (out_free && r_cnt >= n_act) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs: ready, multiplier operands, rom address
    always_comb begin
        o_in_ready = 1'b0;
        mul_a = 18'sd0;
        mul_b = 18'sd0;
        rom_addr = r_k;
        unique case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_DOT_MUL: begin
                mul_a = 18'(r_item.value);
                mul_b = 18'(r_coef[pos_c[AW-1:0]]);
            end
            S_ROM0:    rom_addr = a_clamp[15:6];
            S_ROM1:    rom_addr = r_k + 10'd1;
            S_SIG_MUL: begin
                mul_a = dsig;
                mul_b = signed'({12'd0, r_f});
            end
            S_SP_MUL: begin
                mul_a = dsp;
                mul_b = signed'({12'd0, r_f});
            end
            S_GRD_MUL: begin
                mul_a = 18'(r_buf[r_cnt[AW-1:0]]);
                mul_b = r_w;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // lookup pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_ROM0) begin
            r_v <= v_c;
            r_f <= a_clamp[5:0];
            r_k <= a_clamp[15:6];
            r_a_big <= (a_mag >= 28'(LIM_EXP));
            r_lab <= r_item.label;
        end
        if (r_state == S_ROM1) begin
            r_t0 <= rom_q;
        end
        if (r_state == S_ROM2) begin
            r_t1 <= rom_q;
        end
        if (r_state == S_SP_MUL) begin
            r_s <= s_i;
        end
        if (r_state == S_LOSS) begin
            r_w <= w_c;
        end
        if (r_state == S_DOT_MUL) begin
            r_buf[pos_c[AW-1:0]] <= r_item.value;
        end
    end

    // accumulators, coefficients and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FEATURES; i++) begin
                r_coef[i] <= 16'sd0;
                r_grad[i] <= 48'sd0;
            end
            r_loss <= 48'sd0;
            r_pos <= 6'd0;
            r_dot <= 40'sd0;
            r_cnt <= 6'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= 6'd0;
                    if (in_acc && i_in_data.mode == MODE_LOAD && i_in_data.index < MAX6) begin
                        r_coef[i_in_data.index[AW-1:0]] <= i_in_data.value;
                    end
                    if (in_acc && i_in_data.mode == MODE_CLEAR) begin
                        for (int i = 0; i < MAX_FEATURES; i++) begin
                            r_grad[i] <= 48'sd0;
                        end
                        r_loss <= 48'sd0;
                        r_pos <= 6'd0;
                        r_dot <= 40'sd0;
                    end
                end
                S_DOT_ACC: begin
                    r_dot <= r_dot + 40'(r_prod);
                    r_pos <= (pos_inc >= {1'b0, n_act}) ? 6'd0 : pos_inc[5:0];
                end
                S_ROM0: r_dot <= 40'sd0;
                S_LOSS: begin
                    r_loss <= sat_add(r_loss, 48'(term_c));
                    r_cnt <= 6'd0;
                end
                S_GRD_ACC: begin
                    r_grad[r_cnt[AW-1:0]] <= sat_add(r_grad[r_cnt[AW-1:0]], 48'(r_prod));
                    r_cnt <= cnt_inc[5:0];
                end
                S_READ: begin
                    if (out_free && r_cnt < n_act) begin
                        r_cnt <= cnt_inc[5:0];
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // output register: gradients then loss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_READ && out_free) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && out_free) begin
            if (r_cnt < n_act) begin
                r_out.out_index <= r_cnt;
                r_out.out_value <= r_grad[r_cnt[AW-1:0]];
                r_out.is_loss <= 1'b0;
                r_out.last_result <= 1'b0;
            end else begin
                r_out.out_index <= 6'd0;
                r_out.out_value <= r_loss;
                r_out.is_loss <= 1'b1;
                r_out.last_result <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data = r_out;

    // checks
    `LLG_ASSERT_NXT(a_read_starts, i_clk, i_rst_n, in_acc && i_in_data.mode == MODE_READ, r_state == S_READ)
    `LLG_ASSERT_IMP(a_loss_is_last, i_clk, i_rst_n, r_ov && r_out.is_loss, r_out.last_result)
    `LLG_ASSERT_IMP(a_grad_in_range, i_clk, i_rst_n, r_state == S_GRD_MUL || r_state == S_GRD_ACC, r_cnt < n_act)
    `LLG_ASSERT_NXT(a_clear_zeroes, i_clk, i_rst_n, in_acc && i_in_data.mode == MODE_CLEAR, r_loss == 48'sd0 && r_pos == 6'd0)

endmodule

[rtl/llg_rom.sv]
// sigmoid and softplus lookup rom, 1/64 step, registered read
// depends on llg_pkg for the table builder
module llg_rom
    import llg_pkg::*;
(
    input  logic        i_clk,
    input  logic [9:0]  i_addr,
    output logic [33:0] o_data
);

    localparam t_rom ROM = build_rom();

    // synchronous read
    always_ff @(posedge i_clk) begin
        o_data <= ROM[i_addr];
    end

endmodule
